// ----- rtl/gpr_pkg.sv -----
package gpr_pkg;

  // Frame size defaults
  localparam int unsigned COLUMNS_DEF = 1024;
  localparam int unsigned ROWS_DEF    = 1024;

  // Field and register widths
  localparam int unsigned PIX_W   = 10;
  localparam int unsigned LIM_W   = 31;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned COEF_W  = 32;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned NCOEF   = 6;

  // Datapath widths: row/column terms, split halves, products, dividend, quotient, depth-row product, depth
  localparam int unsigned CW      = 43;
  localparam int unsigned LOW_W   = 22;
  localparam int unsigned HIGH_W  = CW - LOW_W;
  localparam int unsigned PW      = 88;
  localparam int unsigned NW      = PW + FRAC_W;
  localparam int unsigned QW      = 32;
  localparam int unsigned MUL_W   = 2 * COEF_W;
  localparam int unsigned DEPTH_W = MUL_W - FRAC_W + 2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_COEF0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF3 = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF4 = 3'd4;
  localparam logic [IDX_W-1:0] REG_COEF5 = 3'd5;
  localparam logic [IDX_W-1:0] REG_LIMIT = 3'd6;
  localparam logic [IDX_W-1:0] REG_START = 3'd7;

  localparam logic [LIM_W-1:0] LIMIT_RST = 31'd1966080;
  localparam logic [PIX_W-1:0] START_RST = 10'd512;

  // Cross products: operand pairs over terms c1..c6 (index 0..5)
  localparam int unsigned NPROD = 6;
  localparam logic [2:0] PROD_A [NPROD] = '{3'd0, 3'd4, 3'd5, 3'd4, 3'd0, 3'd1};
  localparam logic [2:0] PROD_B [NPROD] = '{3'd3, 3'd1, 3'd3, 3'd2, 3'd2, 3'd5};

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FAR  = 2'd1,
    ST_ROW  = 2'd2,
    ST_ZDIV = 2'd3
  } status_e;

  typedef struct packed {
    logic bad;
    logic zdiv;
    logic negx;
    logic negz;
  } side_t;

endpackage

// ----- rtl/gpr_div.sv -----
module gpr_div #(
  parameter int unsigned NW = gpr_pkg::NW,
  parameter int unsigned DW = gpr_pkg::PW,
  parameter int unsigned QW = gpr_pkg::QW
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o
);

  localparam int unsigned RW = (NW > DW + QW) ? NW : DW + QW;

  logic [RW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];

  // Entry stage: flag quotients that do not fit in QW bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= RW'(num_i) >= (RW'(den_i) << QW);
    end
  end

  // One restoring step per stage, most significant quotient bit first
  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int unsigned SH = QW - k;
    logic [RW:0]   diff;
    logic          ge;

    always_comb begin
      diff = {1'b0, rem_q[k-1]} - {1'b0, RW'(den_q[k-1]) << SH};
      ge   = !diff[RW];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[RW-1:0] : rem_q[k-1];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= {quo_q[k-1][QW-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

// ----- rtl/ground_plane_remap_unit.sv -----
// Pipeline: 5 front stages, 33 stages in each divider and 3 back stages;
// throughput one item per cycle while results are taken at the output.
// The two restoring dividers set the depth; the whole pipe freezes
// while a result waits at the output.
// Reset (rst_ni low, asynchronous) empties the pipe, clears the six
// coefficient registers and loads depth limit 30.0 and start row 512.
module ground_plane_remap_unit #(
  parameter int unsigned COLUMNS = gpr_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = gpr_pkg::ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [gpr_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [gpr_pkg::CFG_W-1:0]   cfg_data_i,
  // pixel item
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [gpr_pkg::PIX_W-1:0]   pixel_col_i,
  input  logic [gpr_pkg::PIX_W-1:0]   pixel_row_i,
  // ground point item
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [gpr_pkg::QW-1:0] ground_x_o,
  output logic signed [gpr_pkg::QW-1:0] ground_z_o,
  output logic [1:0]                  remap_status_o
);

  localparam int unsigned CW     = gpr_pkg::CW;
  localparam int unsigned PW     = gpr_pkg::PW;
  localparam int unsigned NW     = gpr_pkg::NW;
  localparam int unsigned QW     = gpr_pkg::QW;
  localparam int unsigned LO     = gpr_pkg::LOW_W;
  localparam int unsigned HI     = gpr_pkg::HIGH_W;
  localparam int unsigned MW     = gpr_pkg::MUL_W;
  localparam int unsigned DPW    = gpr_pkg::DEPTH_W;
  localparam int unsigned FR     = gpr_pkg::FRAC_W;
  localparam int unsigned NPROD  = gpr_pkg::NPROD;
  // front stages, divider stages, back stages
  localparam int unsigned NST    = 5 + QW + 1 + 3;

  // --------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------
  logic [gpr_pkg::CFG_W-1:0] coef_q [gpr_pkg::NCOEF];
  logic [gpr_pkg::LIM_W-1:0] limit_q;
  logic [gpr_pkg::PIX_W-1:0] start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gpr_pkg::NCOEF; i++) coef_q[i] <= '0;
      limit_q <= gpr_pkg::LIMIT_RST;
      start_q <= gpr_pkg::START_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gpr_pkg::REG_COEF0: coef_q[0] <= cfg_data_i;
        gpr_pkg::REG_COEF1: coef_q[1] <= cfg_data_i;
        gpr_pkg::REG_COEF2: coef_q[2] <= cfg_data_i;
        gpr_pkg::REG_COEF3: coef_q[3] <= cfg_data_i;
        gpr_pkg::REG_COEF4: coef_q[4] <= cfg_data_i;
        gpr_pkg::REG_COEF5: coef_q[5] <= cfg_data_i;
        gpr_pkg::REG_LIMIT: limit_q   <= cfg_data_i[gpr_pkg::LIM_W-1:0];
        gpr_pkg::REG_START: start_q   <= cfg_data_i[gpr_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient halves, each a signed Q16.16 word
  logic signed [QW-1:0] p0, p2, p3, p4, p6, p7, p8, p10, p11, wx, wz, off;
  assign p0  = signed'(coef_q[0][31:0]);
  assign p2  = signed'(coef_q[0][63:32]);
  assign p3  = signed'(coef_q[1][31:0]);
  assign p4  = signed'(coef_q[1][63:32]);
  assign p6  = signed'(coef_q[2][31:0]);
  assign p7  = signed'(coef_q[2][63:32]);
  assign p8  = signed'(coef_q[3][31:0]);
  assign p10 = signed'(coef_q[3][63:32]);
  assign p11 = signed'(coef_q[4][31:0]);
  assign wx  = signed'(coef_q[4][63:32]);
  assign wz  = signed'(coef_q[5][31:0]);
  assign off = signed'(coef_q[5][63:32]);

  // --------------------------------------------------------------------
  // Pipeline control: every stage advances together; input ready follows
  // output ready combinationally, so an item enters while a result is taken.
  // --------------------------------------------------------------------
  logic           adv;
  logic [NST-1:0] vld_q;

  assign adv        = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // --------------------------------------------------------------------
  // Stage 1: row and column terms, range check
  // --------------------------------------------------------------------
  logic signed [CW-1:0] c_d [NPROD];
  logic signed [CW-1:0] c_q [NPROD];
  logic signed [CW-1:0] su, sv;
  logic                 bad_d, bad1_q;

  always_comb begin
    su = CW'(signed'({1'b0, pixel_col_i}));
    sv = CW'(signed'({1'b0, pixel_row_i}));
    c_d[0] = CW'(p0)  - CW'(p8)  * su;  // c1
    c_d[1] = CW'(p4)  - CW'(p8)  * sv;  // c2
    c_d[2] = CW'(p11) * sv - CW'(p7);   // c3
    c_d[3] = CW'(p6)  - CW'(p10) * sv;  // c4
    c_d[4] = CW'(p2)  - CW'(p10) * su;  // c5
    c_d[5] = CW'(p11) * su - CW'(p3);   // c6
    // rows above the start row and pixels off the frame give zeros
    bad_d = (pixel_row_i < start_q) || (32'(pixel_col_i) >= COLUMNS) ||
            (32'(pixel_row_i) >= ROWS);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q    <= c_d;
      bad1_q <= bad_d;
    end
  end

  // --------------------------------------------------------------------
  // Stage 2: partial products of the six cross products, operands split
  // into an unsigned low part and a signed high part
  // --------------------------------------------------------------------
  logic signed [2*LO+1:0]  pll_q [NPROD];
  logic signed [LO+HI:0]   plh_q [NPROD];
  logic signed [LO+HI:0]   phl_q [NPROD];
  logic signed [2*HI-1:0]  phh_q [NPROD];
  logic                    bad2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NPROD; k++) begin
        pll_q[k] <= signed'({1'b0, c_q[gpr_pkg::PROD_A[k]][LO-1:0]}) *
                    signed'({1'b0, c_q[gpr_pkg::PROD_B[k]][LO-1:0]});
        plh_q[k] <= signed'({1'b0, c_q[gpr_pkg::PROD_A[k]][LO-1:0]}) *
                    signed'(c_q[gpr_pkg::PROD_B[k]][CW-1:LO]);
        phl_q[k] <= signed'(c_q[gpr_pkg::PROD_A[k]][CW-1:LO]) *
                    signed'({1'b0, c_q[gpr_pkg::PROD_B[k]][LO-1:0]});
        phh_q[k] <= signed'(c_q[gpr_pkg::PROD_A[k]][CW-1:LO]) *
                    signed'(c_q[gpr_pkg::PROD_B[k]][CW-1:LO]);
      end
      bad2_q <= bad1_q;
    end
  end

  // --------------------------------------------------------------------
  // Stage 3: recombine partial products
  // --------------------------------------------------------------------
  logic signed [PW-1:0] prod_q [NPROD];
  logic                 bad3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NPROD; k++) begin
        prod_q[k] <= (PW'(phh_q[k]) <<< (2 * LO)) + (PW'(plh_q[k]) <<< LO) +
                     (PW'(phl_q[k]) <<< LO) + PW'(pll_q[k]);
      end
      bad3_q <= bad2_q;
    end
  end

  // --------------------------------------------------------------------
  // Stage 4: determinant and the two Cramer numerators
  // --------------------------------------------------------------------
  logic signed [PW-1:0] det_q, nx_q, nz_q;
  logic                 bad4_q, zdiv4_q;
  logic signed [PW-1:0] det_d;

  assign det_d = prod_q[0] - prod_q[1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      det_q   <= det_d;
      nx_q    <= prod_q[2] - prod_q[3];
      nz_q    <= prod_q[4] - prod_q[5];
      bad4_q  <= bad3_q;
      zdiv4_q <= (det_d == '0);
    end
  end

  // --------------------------------------------------------------------
  // Stage 5: magnitudes and quotient signs; scale dividends to Q16.16
  // --------------------------------------------------------------------
  logic [PW-1:0]   dmag_q;
  logic [NW-1:0]   nxmag_q, nzmag_q;
  gpr_pkg::side_t  side5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dmag_q       <= det_q[PW-1] ? PW'(-det_q) : PW'(det_q);
      nxmag_q      <= NW'(nx_q[PW-1] ? PW'(-nx_q) : PW'(nx_q)) << FR;
      nzmag_q      <= NW'(nz_q[PW-1] ? PW'(-nz_q) : PW'(nz_q)) << FR;
      side5_q.bad  <= bad4_q;
      side5_q.zdiv <= zdiv4_q;
      side5_q.negx <= nx_q[PW-1] ^ det_q[PW-1];
      side5_q.negz <= nz_q[PW-1] ^ det_q[PW-1];
    end
  end

  // --------------------------------------------------------------------
  // Dividers: QW+1 stages each; sideband travels alongside
  // --------------------------------------------------------------------
  logic [QW-1:0]  quox, quoz;
  logic           ovfx, ovfz;
  gpr_pkg::side_t sbd_q [QW+1];

  gpr_div #(.NW(NW), .DW(PW), .QW(QW)) u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (nxmag_q),
    .den_i (dmag_q),
    .quo_o (quox),
    .ovf_o (ovfx)
  );

  gpr_div #(.NW(NW), .DW(PW), .QW(QW)) u_div_z (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (nzmag_q),
    .den_i (dmag_q),
    .quo_o (quoz),
    .ovf_o (ovfz)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sbd_q[0] <= side5_q;
      for (int k = 1; k <= QW; k++) sbd_q[k] <= sbd_q[k-1];
    end
  end

  // --------------------------------------------------------------------
  // Stage 6: apply sign, saturate to the signed 32-bit range
  // --------------------------------------------------------------------
  localparam logic [QW-1:0] MIN_MAG = {1'b1, {(QW-1){1'b0}}};

  logic signed [QW-1:0] gx_q, gz_q;
  gpr_pkg::side_t       side6_q;

  function automatic logic signed [QW-1:0] sat_quo(input logic [QW-1:0] q,
                                                   input logic ovf,
                                                   input logic neg);
    logic signed [QW-1:0] r;
    if (neg) begin
      r = (ovf || q > MIN_MAG) ? signed'(MIN_MAG) : signed'(-q);
    end else begin
      r = (ovf || q[QW-1]) ? signed'(~MIN_MAG) : signed'(q);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gx_q    <= sat_quo(quox, ovfx, sbd_q[QW].negx);
      gz_q    <= sat_quo(quoz, ovfz, sbd_q[QW].negz);
      side6_q <= sbd_q[QW];
    end
  end

  // --------------------------------------------------------------------
  // Stage 7: depth-row products
  // --------------------------------------------------------------------
  logic signed [MW-1:0] mx_q, mz_q;
  logic signed [QW-1:0] gx7_q, gz7_q;
  gpr_pkg::side_t       side7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx_q    <= MW'(wx) * MW'(gx_q);
      mz_q    <= MW'(wz) * MW'(gz_q);
      gx7_q   <= gx_q;
      gz7_q   <= gz_q;
      side7_q <= side6_q;
    end
  end

  // --------------------------------------------------------------------
  // Stage 8: depth (floor to Q16.16, add offset), limit test, output
  // --------------------------------------------------------------------
  logic signed [DPW-1:0] depth;
  logic                  far;
  gpr_pkg::status_e      st_d;
  logic signed [QW-1:0]  x_q, z_q;
  gpr_pkg::status_e      st_q;

  always_comb begin
    depth = DPW'(mx_q >>> FR) + DPW'(mz_q >>> FR) + DPW'(off);
    far   = depth > signed'(DPW'({1'b0, limit_q}));
    priority if (side7_q.bad)  st_d = gpr_pkg::ST_ROW;
    else if (side7_q.zdiv)     st_d = gpr_pkg::ST_ZDIV;
    else if (far)              st_d = gpr_pkg::ST_FAR;
    else                       st_d = gpr_pkg::ST_OK;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q <= st_d;
      x_q  <= (st_d == gpr_pkg::ST_OK) ? gx7_q : '0;
      z_q  <= (st_d == gpr_pkg::ST_OK) ? gz7_q : '0;
    end
  end

  assign ground_x_o     = x_q;
  assign ground_z_o     = z_q;
  assign remap_status_o = st_q;

  // --------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------
  // a result other than ok carries zeros
  a_zero_unless_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (remap_status_o != gpr_pkg::ST_OK) |->
      (ground_x_o == '0) && (ground_z_o == '0))
    else $error("nonzero point with error status");

  // a frozen pipe keeps its occupancy
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vld_q))
    else $error("pipeline occupancy changed during stall");

  // an accepted item occupies the first stage next cycle
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted item lost at entry");

endmodule

// ----- sim/ground_plane_remap_unit_tb.sv -----
module ground_plane_remap_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [gpr_pkg::PIX_W-1:0] col;
    logic [gpr_pkg::PIX_W-1:0] row;
  } pixel_t;

  typedef struct {
    logic signed [gpr_pkg::QW-1:0] x;
    logic signed [gpr_pkg::QW-1:0] z;
    gpr_pkg::status_e              status;
  } ground_pt_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_CYCLES    = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [gpr_pkg::IDX_W-1:0] cfg_idx_i = gpr_pkg::REG_COEF0;
  logic [gpr_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [gpr_pkg::PIX_W-1:0] pixel_col_i = '0;
  logic [gpr_pkg::PIX_W-1:0] pixel_row_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [gpr_pkg::QW-1:0] ground_x_o;
  logic signed [gpr_pkg::QW-1:0] ground_z_o;
  logic [1:0] remap_status_o;

  ground_plane_remap_unit dut (.*);

  always #1 clk_i = ~clk_i;

  // Shadow copy of the register file, written only while the block is idle
  logic [gpr_pkg::CFG_W-1:0] coef_shadow [gpr_pkg::NCOEF];
  logic [gpr_pkg::LIM_W-1:0] limit_shadow = gpr_pkg::LIMIT_RST;
  logic [gpr_pkg::PIX_W-1:0] start_shadow = gpr_pkg::START_RST;

  pixel_t     pixel_q [$];
  ground_pt_t ground_q [$];

  int  snd_idle = 26;
  int  rcv_idle = 62;
  int  mismatches = 0;
  int  stall_cnt = 0;
  bit  in_fire = 1'b0;
  bit  hold_start = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_cnt = 0;

  // (|num| << 16) / |den|, truncated toward zero, saturated to 32 bits
  function automatic logic signed [gpr_pkg::QW-1:0] quot_q16(logic signed [127:0] num,
                                                             logic signed [127:0] den);
    logic [127:0] n, d, q;
    logic neg;
    neg = num[127] ^ den[127];
    n = num[127] ? -num : num;
    d = den[127] ? -den : den;
    q = (n << gpr_pkg::FRAC_W) / d;
    if (neg) return (q > 128'h8000_0000) ? 32'sh8000_0000 : -q[gpr_pkg::QW-1:0];
    return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[gpr_pkg::QW-1:0];
  endfunction

  // Solve the two plane equations for one pixel against the shadow registers
  function automatic ground_pt_t remap_pixel(pixel_t px);
    ground_pt_t r;
    longint u, v, p0, p2, p3, p4, p6, p7, p8, p10, p11, wx, wz, off, gx, gz, depth;
    logic signed [127:0] c1, c2, c3, c4, c5, c6, det;
    r.x = '0;
    r.z = '0;
    u = px.col;
    v = px.row;
    if (px.row < start_shadow) begin
      r.status = gpr_pkg::ST_ROW;
      return r;
    end
    p0  = $signed(coef_shadow[0][31:0]);  p2  = $signed(coef_shadow[0][63:32]);
    p3  = $signed(coef_shadow[1][31:0]);  p4  = $signed(coef_shadow[1][63:32]);
    p6  = $signed(coef_shadow[2][31:0]);  p7  = $signed(coef_shadow[2][63:32]);
    p8  = $signed(coef_shadow[3][31:0]);  p10 = $signed(coef_shadow[3][63:32]);
    p11 = $signed(coef_shadow[4][31:0]);  wx  = $signed(coef_shadow[4][63:32]);
    wz  = $signed(coef_shadow[5][31:0]);  off = $signed(coef_shadow[5][63:32]);
    c1 = p0 - p8 * u;
    c5 = p2 - p10 * u;
    c6 = p11 * u - p3;
    c2 = p4 - p8 * v;
    c4 = p6 - p10 * v;
    c3 = p11 * v - p7;
    det = c1 * c4 - c5 * c2;
    if (det == 0) begin
      r.status = gpr_pkg::ST_ZDIV;
      return r;
    end
    gx = quot_q16(c6 * c4 - c5 * c3, det);
    gz = quot_q16(c1 * c3 - c2 * c6, det);
    depth = ((wx * gx) >>> gpr_pkg::FRAC_W) + ((wz * gz) >>> gpr_pkg::FRAC_W) + off;
    if (depth > longint'(limit_shadow)) begin
      r.status = gpr_pkg::ST_FAR;
      return r;
    end
    r.x = gx[gpr_pkg::QW-1:0];
    r.z = gz[gpr_pkg::QW-1:0];
    r.status = gpr_pkg::ST_OK;
    return r;
  endfunction

  // Sender: hold valid and payload until accepted, then advance or drop valid
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (pixel_q.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
        in_valid_i  <= 1'b1;
        pixel_col_i <= pixel_q[0].col;
        pixel_row_i <= pixel_q[0].row;
        pixel_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the pipe up
  always @(negedge clk_i) begin
    if (hold_start && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_cnt    <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // Monitor: predict on each accepted pixel, check each accepted result
  always @(posedge clk_i) begin
    ground_pt_t exp_pt;
    in_fire <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) ground_q.push_back(remap_pixel('{pixel_col_i, pixel_row_i}));
      if (out_valid_o && out_ready_i) begin
        if (ground_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result x=%0d z=%0d status=%0d",
                                         ground_x_o, ground_z_o, remap_status_o);
        end else begin
          exp_pt = ground_q.pop_front();
          if (ground_x_o !== exp_pt.x || ground_z_o !== exp_pt.z ||
              remap_status_o !== exp_pt.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp x=%0d z=%0d st=%0d, got x=%0d z=%0d st=%0d",
                       exp_pt.x, exp_pt.z, exp_pt.status,
                       ground_x_o, ground_z_o, remap_status_o);
          end
        end
      end
      // Watchdog: count cycles in which neither side moves an item
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Drive one register write; update the shadow copy when the write is driven
  task automatic write_reg(logic [gpr_pkg::IDX_W-1:0] idx, logic [gpr_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    case (idx)
      gpr_pkg::REG_LIMIT: limit_shadow = val[gpr_pkg::LIM_W-1:0];
      gpr_pkg::REG_START: start_shadow = val[gpr_pkg::PIX_W-1:0];
      default:            coef_shadow[idx] = val;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Wait until the pipe is empty and every result is back
  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid_i || ground_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Coefficient half: modest camera-like magnitude, or any 32-bit pattern
  function automatic logic [31:0] coef_half(bit wild);
    logic [31:0] m;
    if (wild) return $urandom;
    m = $urandom & ((32'd1 << $urandom_range(8, 22)) - 1);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  task automatic load_coefs(bit wild);
    for (int i = 0; i < gpr_pkg::NCOEF; i++)
      write_reg(i[gpr_pkg::IDX_W-1:0], {coef_half(wild), coef_half(wild)});
  endtask

  task automatic push_pixel(int col, int row);
    pixel_q.push_back('{col[gpr_pkg::PIX_W-1:0], row[gpr_pkg::PIX_W-1:0]});
  endtask

  // Mostly rows at or below the start row so the solver is exercised
  task automatic push_random(int count);
    repeat (count) begin
      if ($urandom_range(0, 9) < 8)
        push_pixel($urandom_range(0, 1023), $urandom_range(start_shadow, 1023));
      else
        push_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
    end
  endtask

  initial begin
    for (int i = 0; i < gpr_pkg::NCOEF; i++) coef_shadow[i] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: rows above 512 give row status, the rest a zero divisor
    push_pixel(0, 0);       push_pixel(1023, 1023); push_pixel(0, 1023);
    push_pixel(1023, 511);  push_pixel(512, 512);   push_pixel(341, 682);
    wait_idle();

    // Singular but nonzero system: p0 = p2 and p4 = p6, no u or v terms
    write_reg(gpr_pkg::REG_COEF0, {32'sh0003_0000, 32'sh0003_0000});
    write_reg(gpr_pkg::REG_COEF1, {32'sh0002_0000, 32'sh0001_0000});
    write_reg(gpr_pkg::REG_COEF2, {32'sh0005_0000, 32'sh0002_0000});
    write_reg(gpr_pkg::REG_START, 10'd0);
    push_pixel(0, 0); push_pixel(1023, 1023); push_pixel(700, 3);
    wait_idle();

    // Camera-like setup, widest depth limit: mostly valid points and saturation
    load_coefs(1'b0);
    write_reg(gpr_pkg::REG_LIMIT, 31'h7FFF_FFFF);
    push_pixel(0, 0); push_pixel(1023, 0); push_pixel(0, 1023); push_pixel(1023, 1023);
    push_pixel(682, 341); push_pixel(341, 682);
    push_random(150);
    wait_idle();

    // Zero depth limit, last row only
    load_coefs(1'b0);
    write_reg(gpr_pkg::REG_LIMIT, 31'd0);
    write_reg(gpr_pkg::REG_START, 10'd1023);
    push_pixel(5, 1022); push_pixel(5, 1023); push_pixel(1023, 1023);
    push_random(140);
    wait_idle();

    // Receiver holds off while the sender keeps offering pixels
    load_coefs(1'b0);
    write_reg(gpr_pkg::REG_LIMIT, 31'd1966080);
    write_reg(gpr_pkg::REG_START, 10'd200);
    push_random(200);
    hold_start = 1'b1;
    wait_idle();

    snd_idle = 62;
    rcv_idle = 26;
    for (int ph = 0; ph < 4; ph++) begin
      load_coefs(ph[0]);
      write_reg(gpr_pkg::REG_LIMIT, $urandom);
      write_reg(gpr_pkg::REG_START, $urandom_range(0, 1023));
      push_random(190);
      wait_idle();
    end

    snd_idle = 0;
    rcv_idle = 0;
    for (int ph = 0; ph < 2; ph++) begin
      load_coefs(ph[0]);
      write_reg(gpr_pkg::REG_LIMIT, ph ? 31'h7FFF_FFFF : $urandom_range(0, 31'h00FF_FFFF));
      write_reg(gpr_pkg::REG_START, ph ? 10'd0 : $urandom_range(0, 700));
      push_random(190);
      wait_idle();
    end

    if (mismatches == 0 && ground_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/gpr_pkg.sv
rtl/gpr_div.sv
rtl/ground_plane_remap_unit.sv
sim/ground_plane_remap_unit_tb.sv
